>>> rtl/dmhq_pkg.sv
// Shared constants for the d-ary min-heap priority queue.
package dmhq_pkg;
    localparam int DEF_CAPACITY      = 64;
    localparam int DEF_PRIORITY_BITS = 16;
    localparam int DEF_VALUE_BITS    = 32;
    localparam int ARITY_BITS        = 3;
    localparam logic [ARITY_BITS-1:0] ARITY_RESET = 3'd2;
    // status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    // operation codes
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;
    // ceil(2^17/3), exact x/3 for x below 2^17
    localparam int RECIP3_SHIFT = 17;
    localparam logic [16:0] RECIP3 = 17'd43691;
endpackage

>>> rtl/dmhq_mem.sv
// Entry store: one write port, one read port with registered read data.
module dmhq_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 48,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end
endmodule

>>> rtl/dary_min_heap_queue.sv
// Each heap level walked reads the parent, then each child, on the single read port;
// extract first reads the root and the last entry.
// One request is processed at a time; the next is taken once the result is loaded.
// Reset (rst_n low, async) clears count, arity (to 2) and control; store is not cleared.
module dary_min_heap_queue #(
    parameter int CAPACITY      = dmhq_pkg::DEF_CAPACITY,
    parameter int PRIORITY_BITS = dmhq_pkg::DEF_PRIORITY_BITS,
    parameter int VALUE_BITS    = dmhq_pkg::DEF_VALUE_BITS,
    localparam int CW  = $clog2(CAPACITY + 1),
    localparam int IDW = ((PRIORITY_BITS + VALUE_BITS + 7) / 8) * 8,
    localparam int ODW = ((PRIORITY_BITS + VALUE_BITS + 2 + CW + 1 + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dmhq_pkg::ARITY_BITS-1:0]     cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [IDW-1:0]                      s_axis_tdata,  // priority_req, item_value
    input  logic                                s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_priority, out_value, status, entry_count, is_empty
    output logic [ODW-1:0]                      m_axis_tdata
);
    import dmhq_pkg::*;

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int EW  = PRIORITY_BITS + VALUE_BITS;
    localparam int XW  = AW + 3;
    localparam int PW  = AW + RECIP3_SHIFT;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EX0  = 3'd1;
    localparam logic [2:0] S_EX1  = 3'd2;
    localparam logic [2:0] S_LOOP = 3'd3;
    localparam logic [2:0] S_PAR  = 3'd4;
    localparam logic [2:0] S_CH   = 3'd5;
    localparam logic [2:0] S_CHW  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [ARITY_BITS-1:0] arity_reg;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         pos_reg, pos_next;
    logic [EW-1:0]         entry_reg, entry_next;
    logic [EW-1:0]         best_reg, best_next;
    logic [AW-1:0]         best_pos_reg, best_pos_next;
    logic [2:0]            k_reg, k_next;
    logic [AW-1:0]         cidx_reg, cidx_next;
    logic [EW-1:0]         res_reg, res_next;
    logic [1:0]            st_reg, st_next;
    logic                  ovalid_reg;
    logic [ODW-1:0]        odata_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr, mem_raddr;
    logic [EW-1:0]         mem_wdata, mem_rdata;

    logic [2:0]            d;
    logic [AW-1:0]         pm1, up;
    logic [PW-1:0]         prod3;
    logic [XW-1:0]         child;
    logic                  in_acc, out_free;

    dmhq_mem #(.DEPTH(CAPACITY), .WIDTH(EW), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // effective arity, clamped to 2..4
    always_comb
    begin
        if (arity_reg < 3'd2)
            d = 3'd2;
        else if (arity_reg > 3'd4)
            d = 3'd4;
        else
            d = arity_reg;
    end

    // parent index (pos-1)/d
    assign pm1   = pos_reg - AW'(1);
    assign prod3 = PW'(pm1) * PW'(RECIP3);
    always_comb
    begin
        unique case (d)
            3'd2:    up = pm1 >> 1;
            3'd3:    up = prod3[PW-1 -: AW];
            default: up = pm1 >> 2;
        endcase
    end

    // current child index d*pos + k
    assign child = XW'(d) * XW'(pos_reg) + XW'(k_reg);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        pos_next      = pos_reg;
        entry_next    = entry_reg;
        best_next     = best_reg;
        best_pos_next = best_pos_reg;
        k_next        = k_reg;
        cidx_next     = cidx_reg;
        res_next      = res_reg;
        st_next       = st_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = entry_reg;
        mem_raddr     = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    res_next = '0;
                    st_next  = ST_DONE;
                    if (s_axis_tuser == OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            st_next    = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            entry_next = {s_axis_tdata[PRIORITY_BITS-1:0],
                                          s_axis_tdata[EW-1:PRIORITY_BITS]};
                            pos_next   = count_reg[AW-1:0];
                            count_next = count_reg + CW'(1);
                            state_next = S_LOOP;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        st_next    = ST_EMPTY;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mem_raddr  = '0;
                        state_next = S_EX0;
                    end
                end
            end
            S_EX0:
            begin
                // root arrives; fetch last entry
                res_next   = mem_rdata;
                mem_raddr  = AW'(count_reg - CW'(1));
                count_next = count_reg - CW'(1);
                state_next = S_EX1;
            end
            S_EX1:
            begin
                entry_next = mem_rdata;
                pos_next   = '0;
                state_next = (count_reg == '0) ? S_DONE : S_LOOP;
            end
            S_LOOP:
            begin
                best_next     = entry_reg;
                best_pos_next = pos_reg;
                k_next        = 3'd1;
                if (pos_reg != '0)
                begin
                    mem_raddr  = up;
                    state_next = S_PAR;
                end
                else
                begin
                    state_next = S_CH;
                end
            end
            S_PAR:
            begin
                // move a strictly larger parent down
                if (mem_rdata[EW-1 -: PRIORITY_BITS] > entry_reg[EW-1 -: PRIORITY_BITS])
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = mem_rdata;
                    pos_next   = up;
                    state_next = S_LOOP;
                end
                else
                begin
                    state_next = S_CH;
                end
            end
            S_CH:
            begin
                if (k_reg <= d && child < XW'(count_reg))
                begin
                    mem_raddr  = child[AW-1:0];
                    cidx_next  = child[AW-1:0];
                    state_next = S_CHW;
                end
                else if (best_pos_reg == pos_reg)
                begin
                    mem_we     = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = best_reg;
                    pos_next   = best_pos_reg;
                    state_next = S_LOOP;
                end
            end
            S_CHW:
            begin
                if (mem_rdata[EW-1 -: PRIORITY_BITS] < best_reg[EW-1 -: PRIORITY_BITS])
                begin
                    best_next     = mem_rdata;
                    best_pos_next = cidx_reg;
                end
                k_next     = k_reg + 3'd1;
                state_next = S_CH;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            arity_reg  <= ARITY_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we)
                arity_reg <= cfg_wdata;
            if (state_reg == S_DONE && out_free)
                ovalid_reg <= 1'b1;
            else if (m_axis_tready)
                ovalid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        entry_reg    <= entry_next;
        best_reg     <= best_next;
        best_pos_reg <= best_pos_next;
        k_reg        <= k_next;
        cidx_reg     <= cidx_next;
        res_reg      <= res_next;
        st_reg       <= st_next;
        if (state_reg == S_DONE && out_free)
            odata_reg <= ODW'({(count_reg == '0), count_reg, st_reg,
                               res_reg[VALUE_BITS-1:0], res_reg[EW-1 -: PRIORITY_BITS]});
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule
